FILE: rtl/core/vcpuid_pkg.sv
// ----------------------------------------------------------------------------
// vcpuid_pkg
// Shared types and constants of the virtual CPUID responder: input and result
// beats, table entry layout, register indexes, leaf codes and scan states.
// ----------------------------------------------------------------------------
package vcpuid_pkg;

	localparam int unsigned MAX_ENTRIES_DFLT = 64;

	// opcodes
	localparam logic OP_QUERY = 1'b0;
	localparam logic OP_LOAD  = 1'b1;

	// configuration register indexes
	localparam logic [7:0] CFG_BASIC_LEVEL = 8'd0;
	localparam logic [7:0] CFG_EXT_LEVEL   = 8'd1;
	localparam logic [7:0] CFG_VCPU_COUNT  = 8'd2;

	// register reset values
	localparam logic [31:0] BASIC_LEVEL_RST = 32'h0000_0000;
	localparam logic [31:0] EXT_LEVEL_RST   = 32'h8000_0000;
	localparam logic [6:0]  VCPU_COUNT_RST  = 7'd1;

	// leaf codes
	localparam logic [31:0] LEAF_ZERO         = 32'h0000_0000;
	localparam logic [31:0] LEAF_VERSION      = 32'h0000_0001;
	localparam logic [31:0] LEAF_CACHE        = 32'h0000_0002;
	localparam logic [31:0] LEAF_TOPOLOGY     = 32'h0000_000B;
	localparam logic [31:0] LEAF_XSAVE        = 32'h0000_000D;
	localparam logic [31:0] LEAF_EXT_BASE     = 32'h8000_0000;
	localparam logic [31:0] LEAF_EXT_FEATURES = 32'h8000_0001;

	// topology level types
	localparam logic [1:0] TOPO_TYPE_INVALID = 2'd0;
	localparam logic [1:0] TOPO_TYPE_SMT     = 2'd1;
	localparam logic [1:0] TOPO_TYPE_CORE    = 2'd2;

	localparam logic [31:0] LIMIT_LEAF0_A = 32'd2;

	typedef struct packed {
		logic        opcode;
		logic [31:0] leaf;
		logic [31:0] subleaf;
		logic        check_subleaf;
		logic [31:0] word_a;
		logic [31:0] word_b;
		logic [31:0] word_c;
		logic [31:0] word_d;
		logic [31:0] apic_id;
		logic        limit_mode;
	} in_t;

	typedef struct packed {
		logic [31:0] out_a;
		logic [31:0] out_b;
		logic [31:0] out_c;
		logic [31:0] out_d;
		logic        found;
		logic        per_cpu_pending;
	} out_t;

	typedef struct packed {
		logic [31:0] leaf;
		logic [31:0] subleaf;
		logic        chk;
		logic [31:0] word_a;
		logic [31:0] word_b;
		logic [31:0] word_c;
		logic [31:0] word_d;
	} entry_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_HEAD,
		ST_SCAN
	} state_t;

endpackage

FILE: rtl/core/vcpuid_table.sv
// ----------------------------------------------------------------------------
// vcpuid_table
// Entry store of the CPUID responder: one write port and one read port with
// a registered read.
// ----------------------------------------------------------------------------
module vcpuid_table #(
	parameter int unsigned DEPTH = vcpuid_pkg::MAX_ENTRIES_DFLT,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic               clk,
	input  logic               wr_en,
	input  logic [AW-1:0]      wr_addr,
	input  vcpuid_pkg::entry_t wr_data,
	input  logic [AW-1:0]      rd_addr,
	output vcpuid_pkg::entry_t rd_data
);

	vcpuid_pkg::entry_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

FILE: rtl/core/virtual_cpuid_table_lookup.sv
// ----------------------------------------------------------------------------
// virtual_cpuid_table_lookup
// Virtual CPUID responder: table of loaded leaves plus computed topology leaf.
// ----------------------------------------------------------------------------
// An item beat is taken when start is high and busy is low. A load beat
// appends an entry at the fill count and gives no result; a load on a full
// table is dropped. A query beat for the topology leaf or for a per-CPU
// leaf is answered from logic unless limit mode overrides its leaf:
// result_valid pulses in the next cycle and busy stays low. Any other query
// scans the entry memory, one entry per cycle through its single read port:
// the head state picks the scan start from the middle entry, then the scan
// state checks entries until a hit, an entry above the target leaf or the
// fill count, and a miss above the leaf limit repeats the scan once at the
// basic limit. The result pulses in the cycle after the scan ends.
// Each result is marked by result_valid for exactly one cycle; the receiver
// cannot stall it. Configuration beats (cfg_ready is always high) must be
// made while the block is idle, which the block itself does not enforce;
// unknown indexes are ignored. Reset clears the fill count, state and
// configuration registers but not the result or query payload; no clearing
// pass is run, and no entry at or above the fill count is taken as a hit.
// ----------------------------------------------------------------------------
module virtual_cpuid_table_lookup #(
	parameter int unsigned MAX_ENTRIES = vcpuid_pkg::MAX_ENTRIES_DFLT
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  vcpuid_pkg::in_t  item,
	output logic             result_valid,
	output vcpuid_pkg::out_t result,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [7:0]       cfg_index,
	input  logic [31:0]      cfg_data
);

	localparam int unsigned IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int unsigned CNT_W = $clog2(MAX_ENTRIES + 1);
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_ENTRIES);

	function automatic logic [5:0] topo_shift(input logic [6:0] vcpu);
		logic [6:0] m;
		logic [5:0] r;
		m = vcpu - 7'd1;
		r = '0;
		if (vcpu == 7'd0) begin
			r = 6'd32;
		end else if (vcpu != 7'd1) begin
			for (int i = 0; i < 7; i++) begin
				if (m[i]) begin
					r = 6'(i + 1);
				end
			end
		end
		return r;
	endfunction

	logic [31:0]        basic_level_q;
	logic [31:0]        ext_level_q;
	logic [6:0]         vcpu_count_q;
	logic [CNT_W-1:0]   count_q;
	vcpuid_pkg::state_t state_q, state_nxt;
	logic [31:0]        tgt_q;
	logic [31:0]        sub_q;
	logic [CNT_W-1:0]   idx_q;
	logic               retried_q;
	logic               fix_zero_q;
	vcpuid_pkg::out_t   result_q;
	logic               result_valid_q;

	// table port
	logic               wr_en;
	vcpuid_pkg::entry_t wr_data;
	logic [IDX_W-1:0]   rd_addr;
	vcpuid_pkg::entry_t ent;

	// beat decode
	logic             accept, is_query, override, is_topo, is_pcpu;
	logic             query_lookup, query_direct;
	vcpuid_pkg::out_t direct_res;

	// scan conditions
	logic [CNT_W-1:0] head_idx, start_idx, idx_nxt;
	logic [31:0]      lim;
	logic             in_range, ent_lt, ent_eq, sub_ok, hit, miss, retry;
	logic             scan_done;

	vcpuid_table #(
		.DEPTH(MAX_ENTRIES)
	) u_table (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (count_q[IDX_W-1:0]),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (ent)
	);

	assign busy         = (state_q != vcpuid_pkg::ST_IDLE);
	assign cfg_ready    = 1'b1;
	assign result_valid = result_valid_q;
	assign result       = result_q;

	always_comb begin
		accept   = start && !busy;
		is_query = (item.opcode == vcpuid_pkg::OP_QUERY);
		override = item.limit_mode
			&& ((item.leaf > vcpuid_pkg::LEAF_CACHE && item.leaf < vcpuid_pkg::LEAF_EXT_BASE)
			|| item.leaf > ext_level_q);
		is_topo  = (item.leaf == vcpuid_pkg::LEAF_TOPOLOGY);
		is_pcpu  = (item.leaf == vcpuid_pkg::LEAF_VERSION)
			|| (item.leaf == vcpuid_pkg::LEAF_XSAVE)
			|| (item.leaf == vcpuid_pkg::LEAF_EXT_FEATURES);
		query_lookup = accept && is_query && (override || (!is_topo && !is_pcpu));
		query_direct = accept && is_query && !override && (is_topo || is_pcpu);

		wr_en           = accept && (item.opcode == vcpuid_pkg::OP_LOAD) && (count_q < CNT_MAX);
		wr_data.leaf    = item.leaf;
		wr_data.subleaf = item.subleaf;
		wr_data.chk     = item.check_subleaf;
		wr_data.word_a  = item.word_a;
		wr_data.word_b  = item.word_b;
		wr_data.word_c  = item.word_c;
		wr_data.word_d  = item.word_d;
	end

	// answers that need no table access
	always_comb begin
		direct_res = '0;
		if (is_topo) begin
			direct_res.found = 1'b1;
			direct_res.out_d = item.apic_id;
			if (item.subleaf == 32'd0) begin
				direct_res.out_b = 32'd1;
				direct_res.out_c = {22'd0, vcpuid_pkg::TOPO_TYPE_SMT, item.subleaf[7:0]};
			end else if (item.subleaf == 32'd1) begin
				direct_res.out_a = {26'd0, topo_shift(vcpu_count_q)};
				direct_res.out_b = {25'd0, vcpu_count_q};
				direct_res.out_c = {22'd0, vcpuid_pkg::TOPO_TYPE_CORE, item.subleaf[7:0]};
			end else begin
				direct_res.out_c = {22'd0, vcpuid_pkg::TOPO_TYPE_INVALID, item.subleaf[7:0]};
			end
		end else begin
			direct_res.per_cpu_pending = 1'b1;
		end
	end

	always_comb begin
		head_idx  = count_q >> 1;
		idx_nxt   = idx_q + CNT_W'(1);
		lim       = tgt_q[31] ? ext_level_q : basic_level_q;
		ent_lt    = (ent.leaf < tgt_q);
		ent_eq    = (ent.leaf == tgt_q);
		sub_ok    = !ent.chk || (ent.subleaf == sub_q);
		start_idx = ent_lt ? head_idx : '0;
		in_range  = (idx_q < count_q);
		hit       = in_range && ent_eq && sub_ok;
		miss      = !in_range || (!ent_lt && !ent_eq);
		// a miss above the leaf limit retries once at the basic limit
		retry     = miss && !retried_q && (tgt_q > lim);
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			vcpuid_pkg::ST_IDLE: begin
				if (query_lookup) state_nxt = vcpuid_pkg::ST_HEAD;
			end
			vcpuid_pkg::ST_HEAD: begin
				state_nxt = vcpuid_pkg::ST_SCAN;
			end
			vcpuid_pkg::ST_SCAN: begin
				if (hit) begin
					state_nxt = vcpuid_pkg::ST_IDLE;
				end else if (retry) begin
					state_nxt = vcpuid_pkg::ST_HEAD;
				end else if (miss) begin
					state_nxt = vcpuid_pkg::ST_IDLE;
				end
			end
			default: state_nxt = vcpuid_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		rd_addr   = head_idx[IDX_W-1:0];
		scan_done = 1'b0;
		case (state_q)
			vcpuid_pkg::ST_IDLE: begin
				rd_addr = head_idx[IDX_W-1:0];
			end
			vcpuid_pkg::ST_HEAD: begin
				rd_addr = start_idx[IDX_W-1:0];
			end
			vcpuid_pkg::ST_SCAN: begin
				rd_addr   = retry ? head_idx[IDX_W-1:0] : idx_nxt[IDX_W-1:0];
				scan_done = hit || (miss && !retry);
			end
			default: begin
				rd_addr = head_idx[IDX_W-1:0];
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			basic_level_q  <= vcpuid_pkg::BASIC_LEVEL_RST;
			ext_level_q    <= vcpuid_pkg::EXT_LEVEL_RST;
			vcpu_count_q   <= vcpuid_pkg::VCPU_COUNT_RST;
			count_q        <= '0;
			state_q        <= vcpuid_pkg::ST_IDLE;
			idx_q          <= '0;
			retried_q      <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			state_q        <= state_nxt;
			result_valid_q <= query_direct || scan_done;
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					vcpuid_pkg::CFG_BASIC_LEVEL: basic_level_q <= cfg_data;
					vcpuid_pkg::CFG_EXT_LEVEL:   ext_level_q   <= cfg_data;
					vcpuid_pkg::CFG_VCPU_COUNT:  vcpu_count_q  <= cfg_data[6:0];
					default: ;
				endcase
			end
			if (wr_en) begin
				count_q <= count_q + CNT_W'(1);
			end
			if (query_lookup) begin
				retried_q <= 1'b0;
			end
			if (state_q == vcpuid_pkg::ST_HEAD) begin
				idx_q <= start_idx;
			end
			if (state_q == vcpuid_pkg::ST_SCAN) begin
				if (retry) begin
					retried_q <= 1'b1;
				end else if (!hit && !miss) begin
					idx_q <= idx_nxt;
				end
			end
		end
	end

	// query payload and result words
	always_ff @(posedge clk) begin
		if (query_lookup) begin
			tgt_q      <= override ? vcpuid_pkg::LEAF_CACHE : item.leaf;
			sub_q      <= override ? 32'd0 : item.subleaf;
			fix_zero_q <= !override && item.limit_mode && (item.leaf == vcpuid_pkg::LEAF_ZERO);
		end
		if (state_q == vcpuid_pkg::ST_SCAN && retry) begin
			tgt_q <= basic_level_q;
		end
		if (query_direct) begin
			result_q <= direct_res;
		end else if (scan_done) begin
			result_q.per_cpu_pending <= 1'b0;
			if (hit) begin
				result_q.out_a <= fix_zero_q ? vcpuid_pkg::LIMIT_LEAF0_A : ent.word_a;
				result_q.out_b <= ent.word_b;
				result_q.out_c <= ent.word_c;
				result_q.out_d <= ent.word_d;
				result_q.found <= 1'b1;
			end else begin
				result_q.out_a <= fix_zero_q ? vcpuid_pkg::LIMIT_LEAF0_A : 32'd0;
				result_q.out_b <= 32'd0;
				result_q.out_c <= 32'd0;
				result_q.out_d <= 32'd0;
				result_q.found <= 1'b0;
			end
		end
	end

endmodule
